>>> hdl/four_pole_ladder_lowpass_core_defines.svh
// Assertion macros for the ladder low-pass core
`ifndef FOUR_POLE_LADDER_LOWPASS_CORE_DEFINES_SVH
`define FOUR_POLE_LADDER_LOWPASS_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define FPLL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpll check failed");

// next-cycle implication
`define FPLL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpll check failed");

`endif

>>> hdl/fpll_pkg.sv
// Shared types, constants and helpers for the ladder low-pass core
package fpll_pkg;

  localparam int unsigned MUL_AW = 48;
  localparam int unsigned MUL_BW = 34;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned SUM_W  = 56;

  localparam logic [31:0] FREQ_SCALE_RST = 32'd225948;
  localparam logic [15:0] RES_GAIN_RST   = 16'd0;

  localparam logic REG_FREQ_SCALE = 1'b0;
  localparam logic REG_RES_GAIN   = 1'b1;

  localparam logic [20:0] C_015     = 21'd629146;
  localparam logic [20:0] C_035013  = 21'd1468556;
  localparam logic [20:0] C_03      = 21'd1258291;
  localparam logic [23:0] F_MAX     = 24'hFF_FFFF;

  localparam logic signed [32:0] POLE_HI = 33'sh0_7FFF_0000;
  localparam logic signed [32:0] POLE_LO = -33'sh0_8000_0000;
  localparam logic signed [47:0] S48_HI  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_LO  = -48'sh7FFF_FFFF_FFFF - 48'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    STEP_SCALE,
    STEP_F2,
    STEP_F4,
    STEP_DAMP,
    STEP_FB,
    STEP_GAIN,
    STEP_FBACK,
    STEP_INPUT,
    STEP_P1_X,
    STEP_P1_Y,
    STEP_P2_X,
    STEP_P2_Y,
    STEP_P3_X,
    STEP_P3_Y,
    STEP_P4_X,
    STEP_P4_Y
  } step_t;

  function automatic logic signed [32:0] pole_clamp(input logic signed [SUM_W-1:0] v);
    logic signed [32:0] r;
    if (v > SUM_W'(POLE_HI)) begin
      r = POLE_HI;
    end else if (v < SUM_W'(POLE_LO)) begin
      r = POLE_LO;
    end else begin
      r = v[32:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/four_pole_ladder_lowpass_core.sv
// Top level of the four-pole ladder low-pass core
// Each word takes a 16-bit sample and a cutoff in hertz and yields one filtered
// sample. All sixteen products of a word run one after another through a single
// bit-serial multiplier, each after its own load step, and a final step loads the
// result register, which waits while the output is stalled; the next word is
// taken only once the core is back in idle. The user must write freq_scale at
// byte 0 and resonance_gain at byte 4 through the APB port only while idle; the
// core itself does not enforce this.
`include "four_pole_ladder_lowpass_core_defines.svh"

module four_pole_ladder_lowpass_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_audio_in,
  input  logic        [15:0] in_cutoff_hz,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_audio_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);
  import fpll_pkg::*;

  logic [31:0] freq_scale_r;
  logic [15:0] res_gain_r;

  state_t state_r, state_nxt;
  step_t  step_r;

  logic signed [15:0] audio_r;
  logic        [15:0] hz_r;
  logic        [23:0] f_r;
  logic        [25:0] f2_r;
  logic        [29:0] f4_r;
  logic signed [25:0] q_r;
  logic signed [26:0] fb_r;
  logic        [29:0] g_r;
  logic signed [39:0] x_r;
  logic signed [47:0] s_r, prior_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [32:0] pole1_r, pole2_r, pole3_r, pole4_r;
  logic signed [32:0] new1_r, new2_r, new3_r;
  logic signed [25:0] omf;

  logic                     mul_start, mul_done;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic signed [SUM_W-1:0]  p_q22;
  logic signed [39:0]       x_nxt;
  logic signed [47:0]       s_nxt;
  logic signed [15:0]       y;
  logic                     out_load, wr_en;

  // configuration
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_scale_r <= FREQ_SCALE_RST;
      res_gain_r   <= RES_GAIN_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_FREQ_SCALE: freq_scale_r <= pwdata;
        REG_RES_GAIN:   res_gain_r   <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FREQ_SCALE: prdata = freq_scale_r;
      REG_RES_GAIN:   prdata = {16'd0, res_gain_r};
      default:        prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_done) state_nxt = (step_r == STEP_P4_Y) ? ST_FIN : ST_LOAD;
      end
      ST_FIN: if (!out_valid || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    mul_start = (state_r == ST_LOAD);
    out_load  = (state_r == ST_FIN) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_SCALE;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        step_r <= STEP_SCALE;
      end else if (state_r == ST_MUL && mul_done && step_r != STEP_P4_Y) begin
        step_r <= step_t'(step_r + 4'd1);
      end
    end
  end

  // operand selection
  assign omf = 26'sd4194304 - $signed({2'b00, f_r});

  always_comb begin
    unique case (step_r)
      STEP_SCALE: begin mul_a = MUL_AW'(freq_scale_r); mul_b = MUL_BW'(hz_r); end
      STEP_F2:    begin mul_a = MUL_AW'(f_r);          mul_b = MUL_BW'(f_r); end
      STEP_F4:    begin mul_a = MUL_AW'(f2_r);         mul_b = MUL_BW'(f2_r); end
      STEP_DAMP:  begin mul_a = MUL_AW'(C_015);        mul_b = MUL_BW'(f2_r); end
      STEP_FB:    begin mul_a = MUL_AW'(q_r);          mul_b = MUL_BW'(res_gain_r); end
      STEP_GAIN:  begin mul_a = MUL_AW'(C_035013);     mul_b = MUL_BW'(f4_r); end
      STEP_FBACK: begin mul_a = MUL_AW'(pole4_r);      mul_b = MUL_BW'(fb_r); end
      STEP_INPUT: begin mul_a = MUL_AW'(x_r);          mul_b = MUL_BW'(g_r); end
      STEP_P1_X:  begin mul_a = prior_r;               mul_b = MUL_BW'(C_03); end
      STEP_P1_Y:  begin mul_a = MUL_AW'(pole1_r);      mul_b = MUL_BW'(omf); end
      STEP_P2_X:  begin mul_a = MUL_AW'(pole1_r);      mul_b = MUL_BW'(C_03); end
      STEP_P2_Y:  begin mul_a = MUL_AW'(pole2_r);      mul_b = MUL_BW'(omf); end
      STEP_P3_X:  begin mul_a = MUL_AW'(pole2_r);      mul_b = MUL_BW'(C_03); end
      STEP_P3_Y:  begin mul_a = MUL_AW'(pole3_r);      mul_b = MUL_BW'(omf); end
      STEP_P4_X:  begin mul_a = MUL_AW'(pole3_r);      mul_b = MUL_BW'(C_03); end
      STEP_P4_Y:  begin mul_a = MUL_AW'(pole4_r);      mul_b = MUL_BW'(omf); end
      default:    begin mul_a = '0;                    mul_b = '0; end
    endcase
  end

  fpll_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // product post-processing
  assign p_q22   = mul_p[SUM_W+21:22];
  assign sum_nxt = (step_r == STEP_P1_X) ? SUM_W'(s_r) + p_q22 : sum_r + p_q22;
  assign x_nxt   = {{8{audio_r[15]}}, audio_r, 16'd0} - 40'($signed(mul_p[59:22]));

  always_comb begin
    if ((&mul_p[MUL_PW-1:69]) || !(|mul_p[MUL_PW-1:69])) begin
      s_nxt = mul_p[69:22];
    end else begin
      s_nxt = mul_p[MUL_PW-1] ? S48_LO : S48_HI;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      audio_r <= in_audio_in;
      hz_r    <= in_cutoff_hz;
    end
    if (state_r == ST_MUL && mul_done) begin
      unique case (step_r)
        STEP_SCALE: f_r  <= (|mul_p[47:34]) ? F_MAX : mul_p[33:10];
        STEP_F2:    f2_r <= mul_p[47:22];
        STEP_F4:    f4_r <= mul_p[51:22];
        STEP_DAMP:  q_r  <= 26'sd4194304 - $signed({1'b0, mul_p[46:22]});
        STEP_FB:    fb_r <= mul_p[40:14];
        STEP_GAIN:  g_r  <= mul_p[51:22];
        STEP_FBACK: x_r  <= x_nxt;
        STEP_INPUT: s_r  <= s_nxt;
        STEP_P1_X:  sum_r <= sum_nxt;
        STEP_P1_Y:  begin sum_r <= sum_nxt; new1_r <= pole_clamp(sum_nxt); end
        STEP_P2_X:  sum_r <= sum_nxt;
        STEP_P2_Y:  begin sum_r <= sum_nxt; new2_r <= pole_clamp(sum_nxt); end
        STEP_P3_X:  sum_r <= sum_nxt;
        STEP_P3_Y:  begin sum_r <= sum_nxt; new3_r <= pole_clamp(sum_nxt); end
        STEP_P4_X:  sum_r <= sum_nxt;
        STEP_P4_Y:  sum_r <= sum_nxt;
        default:    ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole1_r <= '0;
      pole2_r <= '0;
      pole3_r <= '0;
      pole4_r <= '0;
      prior_r <= '0;
    end else if (state_r == ST_MUL && mul_done && step_r == STEP_P4_Y) begin
      pole1_r <= new1_r;
      pole2_r <= new2_r;
      pole3_r <= new3_r;
      pole4_r <= pole_clamp(sum_nxt);
      prior_r <= s_r;
    end
  end

  // truncate toward zero
  assign y = pole4_r[31:16] + {15'd0, pole4_r[32] && (|pole4_r[15:0])};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_audio_out <= y;
  end

  `FPLL_ASSERT_NEXT(a_accept_loads, in_valid && !in_stall,
                    state_r == ST_LOAD && step_r == STEP_SCALE)
  `FPLL_ASSERT_IMPL(a_done_in_mul, mul_done, state_r == ST_MUL)
  `FPLL_ASSERT_IMPL(a_out_from_fin, $rose(out_valid), $past(state_r) == ST_FIN)

endmodule

>>> hdl/fpll_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle
module fpll_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [fpll_pkg::MUL_AW-1:0]    a,
  input  logic signed [fpll_pkg::MUL_BW-1:0]    b,
  output logic                                  done,
  output logic signed [fpll_pkg::MUL_PW-1:0]    p
);
  import fpll_pkg::*;

  localparam int unsigned CW = $clog2(MUL_BW);

  logic signed [MUL_PW-1:0] a_sh_r, acc_r;
  logic signed [MUL_BW-1:0] b_r;
  logic [CW-1:0]            cnt_r;
  logic                     busy_r, done_r;
  logic                     last;

  assign last = (cnt_r == CW'(MUL_BW - 1));

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh_r <= MUL_PW'(a);
      b_r    <= b;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= last ? acc_r - a_sh_r : acc_r + a_sh_r;
      end
      a_sh_r <= a_sh_r <<< 1;
      b_r    <= b_r >>> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

>>> test/four_pole_ladder_lowpass_checker.sv
// Watches the ladder filter channels, predicts each filtered word and compares
module four_pole_ladder_lowpass_checker
  import fpll_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_audio_in,
  input  logic        [15:0] in_cutoff_hz,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_audio_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q22 = 64'sd4194304;

  logic [31:0]        cut_scale;
  logic [15:0]        res_gain;
  logic signed [32:0] stage1, stage2, stage3, stage4;
  logic signed [47:0] last_drive;
  logic signed [15:0] filtered_q[$];

  function automatic longint scale_q22(longint a, longint c);
    longint hi, lo;
    hi = a >>> 22;
    lo = a - hi * ONE_Q22;
    return hi * c + ((lo * c) >>> 22);
  endfunction

  function automatic longint limit(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // advances the filter state by one sample, returns the output sample
  function automatic logic signed [15:0] ladder_step(logic signed [15:0] smp,
                                                     logic [15:0] hz);
    longint f, f2, f4, fb, g, omf, x, s, p1, p2, p3, p4, q4, y;
    longint s1, s2, s3, s4;
    s1 = stage1; s2 = stage2; s3 = stage3; s4 = stage4;
    f = (longint'(hz) * longint'(cut_scale)) >> 10;
    if (f > longint'(F_MAX)) f = longint'(F_MAX);
    f2 = (f * f) >> 22;
    f4 = (f2 * f2) >> 22;
    fb = (longint'(res_gain) * (ONE_Q22 - ((longint'(C_015) * f2) >> 22))) >>> 14;
    g = (longint'(C_035013) * f4) >> 22;
    omf = ONE_Q22 - f;
    x = longint'(smp) * 65536 - scale_q22(s4, fb);
    s = limit(scale_q22(x, g), longint'(S48_LO), longint'(S48_HI));
    p1 = s + scale_q22(longint'(last_drive), longint'(C_03)) + scale_q22(s1, omf);
    p2 = p1 + scale_q22(s1, longint'(C_03)) + scale_q22(s2, omf);
    p3 = p2 + scale_q22(s2, longint'(C_03)) + scale_q22(s3, omf);
    p4 = p3 + scale_q22(s3, longint'(C_03)) + scale_q22(s4, omf);
    last_drive = s[47:0];
    stage1 = limit(p1, longint'(POLE_LO), longint'(POLE_HI));
    stage2 = limit(p2, longint'(POLE_LO), longint'(POLE_HI));
    stage3 = limit(p3, longint'(POLE_LO), longint'(POLE_HI));
    q4 = limit(p4, longint'(POLE_LO), longint'(POLE_HI));
    stage4 = q4;
    y = q4 < 0 ? -((-q4) >> 16) : (q4 >> 16);
    return y[15:0];
  endfunction

  assign pending = filtered_q.size();

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst_n) begin
      cut_scale <= FREQ_SCALE_RST;
      res_gain <= RES_GAIN_RST;
      stage1 = '0; stage2 = '0; stage3 = '0; stage4 = '0;
      last_drive = '0;
      filtered_q.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[2] == REG_FREQ_SCALE) begin
          cut_scale <= pwdata;
        end else begin
          res_gain <= pwdata[15:0];
        end
      end
      if (in_valid && !in_stall) filtered_q.push_back(ladder_step(in_audio_in, in_cutoff_hz));
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0d", $time, out_audio_out);
          errors <= errors + 1;
        end else begin
          want = filtered_q.pop_front();
          if (want !== out_audio_out) begin
            $display("%0t: audio_out expected %0d, actual %0d", $time, want, out_audio_out);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> test/four_pole_ladder_lowpass_core_tb.sv
// Stimulus and verdict for the four-pole ladder low-pass core
module four_pole_ladder_lowpass_core_tb;
  import fpll_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [15:0] in_audio_in = '0;
  logic        [15:0] in_cutoff_hz = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [15:0] out_audio_out;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic        [2:0]  paddr = '0;
  logic        [31:0] pwdata = '0;
  logic        [31:0] prdata;
  logic               pready;
  int                 errors, pending;
  int                 gap_max = 9;
  bit                 long_hold = 0;
  int                 quiet = 0;

  always #5 clk = ~clk;

  four_pole_ladder_lowpass_core dut (.*);

  four_pole_ladder_lowpass_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_audio_in, .in_cutoff_hz,
    .out_valid, .out_stall, .out_audio_out, .psel, .penable, .pwrite,
    .pready, .paddr, .pwdata, .errors, .pending
  );

  // watchdog on cycles with no accepted word, no delivered word and no APB select
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // receiver back-pressure
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = $urandom_range(0, gap_max);
      if (long_hold) begin
        n = 3000;
        long_hold = 0;
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  task automatic send_word(logic signed [15:0] smp, logic [15:0] hz);
    int n;
    n = $urandom_range(0, gap_max);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_audio_in <= smp;
    in_cutoff_hz <= hz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_filter(logic [31:0] fs, logic [15:0] res);
    drain();
    write_reg(REG_FREQ_SCALE, fs);
    write_reg(REG_RES_GAIN, res);
  endtask

  initial begin
    logic [31:0] fs_tab[7] = '{32'd225948, 32'd0, 32'hFFFF_FFFF, 32'd1000000,
                               32'd225948, 32'd50000, 32'd3000000};
    logic [15:0] res_tab[7] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd40000,
                                16'd16384, 16'd60000, 16'd8000};
    logic signed [15:0] smp_tab[6] = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1,
                                       16'sd1, 16'sh5555};
    logic [15:0] hz_tab[2] = '{16'hFFFF, 16'd1000};
    logic [15:0] hz;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // extremes at reset settings, then in saturation with negative feedback
    foreach (smp_tab[i]) send_word(smp_tab[i], hz_tab[i % 2]);
    send_word(16'sh7FFF, 16'd0);
    set_filter(32'hFFFF_FFFF, 16'hFFFF);
    foreach (smp_tab[i]) send_word(smp_tab[i], hz_tab[i % 2]);
    send_word(-16'sh8000, 16'hFFFF);
    send_word(16'sh7FFF, 16'hFFFF);
    for (int ph = 0; ph < 7; ph++) begin
      set_filter(fs_tab[ph], res_tab[ph]);
      gap_max = (ph == 4) ? 0 : 9;
      if (ph == 2) long_hold = 1;
      for (int k = 0; k < 200; k++) begin
        hz = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(20, 20000));
        send_word(16'($urandom), hz);
      end
    end
    drain();
    repeat (600) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
